// ----- src/multi_press_button_decoder_defines.svh -----
// Assertion macros for the multi-press button decoder.
`ifndef MULTI_PRESS_BUTTON_DECODER_DEFINES_SVH
`define MULTI_PRESS_BUTTON_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define MPBD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");

`define MPBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`else

`define MPBD_ASSERT_IMPL(label, ante, cons)

`define MPBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/mpbd_pkg.sv -----
package mpbd_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [MS_W-1:0]    DEBOUNCE_RESET   = 16'd50;
	localparam logic [MS_W-1:0]    MULTI_RESET      = 16'd500;
	localparam logic [COUNT_W-1:0] ANIM_COUNT_RESET = 8'd5;

	localparam logic [COUNT_W-1:0] BOOT_PRESSES  = 8'd5;
	localparam logic [COUNT_W-1:0] SLEEP_PRESSES = 8'd4;
	localparam logic [COUNT_W-1:0] NEXT_PRESSES  = 8'd3;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

	// index + 1 needs one bit more than the index
	localparam int unsigned DIVIDEND_W = COUNT_W + 1;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_BOOT  = 3'd1,
		ACT_SLEEP = 3'd2,
		ACT_NEXT  = 3'd3,
		ACT_PRESS = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_MULTI      = 2'd1,
		REG_ANIM_COUNT = 2'd2
	} reg_index_t;

	localparam logic OP_POLL = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

endpackage

// ----- src/mpbd_mod_unit.sv -----
module mpbd_mod_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [mpbd_pkg::DIVIDEND_W-1:0]       dividend,
	input  logic [mpbd_pkg::COUNT_W-1:0]          divisor,
	output mpbd_pkg::mod_status_t                 status,
	output logic [mpbd_pkg::COUNT_W-1:0]          remainder
);

	localparam int unsigned STEPS = mpbd_pkg::DIVIDEND_W;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [mpbd_pkg::DIVIDEND_W-1:0] dividend_q;
	logic [mpbd_pkg::COUNT_W-1:0]    divisor_q;
	logic [mpbd_pkg::COUNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [mpbd_pkg::COUNT_W:0]      trial;
	logic [mpbd_pkg::COUNT_W-1:0]    rem_next;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, dividend_q[mpbd_pkg::DIVIDEND_W-1]};
		if (trial >= {1'b0, divisor_q}) begin
			rem_next = mpbd_pkg::COUNT_W'(trial - {1'b0, divisor_q});
		end else begin
			rem_next = trial[mpbd_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (cnt_q != '0) begin
			dividend_q <= {dividend_q[mpbd_pkg::DIVIDEND_W-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign status.busy = (cnt_q != '0);
	assign status.done = (cnt_q == CNT_W'(1)) && !start;
	assign remainder   = rem_next;

endmodule

// ----- src/multi_press_button_decoder.sv -----
// Multi-press button decoder. Takes one event item per cycle (opcode 1 = button
// edge, 0 = poll) with a millisecond timestamp and returns one result item per
// event through an input register, then decode against the press state into the
// result register. Edges closer than debounce_ms to the last accepted press are
// dropped; presses within multi_press_ms chain into a count that a later poll
// decodes (5 bootloader, 4 sleep, 3 next animation, other counts forwarded).
// After each write of animation_count, a remainder unit precomputes the next
// animation index; in_ready stays low while it is busy. Otherwise the rate is
// one item per cycle, as long as out_ready keeps the result register draining.
`include "multi_press_button_decoder_defines.svh"

module multi_press_button_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	// event channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [mpbd_pkg::TIME_W-1:0]         time_ms,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          action,
	output logic [mpbd_pkg::COUNT_W-1:0]        press_count,
	output logic [mpbd_pkg::COUNT_W-1:0]        animation_index,
	output logic                                bootloader_active,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mpbd_pkg::PADDR_W-1:0]        paddr,
	input  logic [mpbd_pkg::PDATA_W-1:0]        pwdata,
	output logic [mpbd_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	localparam logic [mpbd_pkg::COUNT_W-1:0] IDX_NEXT_RESET =
		mpbd_pkg::COUNT_W'(1 % ((mpbd_pkg::ANIM_COUNT_RESET == 0) ? 1 :
			mpbd_pkg::ANIM_COUNT_RESET));

	// config registers
	logic [mpbd_pkg::MS_W-1:0]    debounce_q;
	logic [mpbd_pkg::MS_W-1:0]    multi_q;
	logic [mpbd_pkg::COUNT_W-1:0] anim_count_q;

	// press state
	logic [mpbd_pkg::TIME_W-1:0]  last_press_q;
	logic [mpbd_pkg::COUNT_W-1:0] pending_q;
	logic [mpbd_pkg::COUNT_W-1:0] index_q;
	logic [mpbd_pkg::COUNT_W-1:0] index_next_q;
	logic                         boot_q;

	// pipeline
	logic                         valid_s1;
	logic                         opcode_s1;
	logic [mpbd_pkg::TIME_W-1:0]  time_s1;
	logic                         out_valid_q;
	mpbd_pkg::action_t            action_q;
	logic [mpbd_pkg::COUNT_W-1:0] count_q;
	logic [mpbd_pkg::COUNT_W-1:0] index_out_q;
	logic                         boot_out_q;

	logic                         cfg_wr;
	logic [1:0]                   reg_sel;
	logic                         advance;
	mpbd_pkg::mod_status_t        mod_status;
	logic [mpbd_pkg::COUNT_W-1:0] mod_rem;
	logic [mpbd_pkg::COUNT_W-1:0] wr_count;
	logic [mpbd_pkg::COUNT_W-1:0] eff_count;

	// step results
	logic [mpbd_pkg::TIME_W-1:0]  elapsed;
	logic                         press_ok;
	logic                         decode_ok;
	logic [mpbd_pkg::COUNT_W-1:0] base_count;
	logic [mpbd_pkg::COUNT_W-1:0] pending_nx;
	logic [mpbd_pkg::COUNT_W-1:0] index_nx;
	logic [mpbd_pkg::COUNT_W-1:0] index_next_nx;
	logic [mpbd_pkg::COUNT_W:0]   index_inc;
	logic                         boot_nx;
	mpbd_pkg::action_t            action_nx;
	logic [mpbd_pkg::COUNT_W-1:0] count_nx;

	assign pready   = 1'b1;
	assign reg_sel  = paddr[3:2];
	assign cfg_wr   = psel && penable && pwrite;
	assign wr_count = pwdata[mpbd_pkg::COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= mpbd_pkg::DEBOUNCE_RESET;
			multi_q      <= mpbd_pkg::MULTI_RESET;
			anim_count_q <= mpbd_pkg::ANIM_COUNT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				mpbd_pkg::REG_DEBOUNCE:   debounce_q   <= pwdata[mpbd_pkg::MS_W-1:0];
				mpbd_pkg::REG_MULTI:      multi_q      <= pwdata[mpbd_pkg::MS_W-1:0];
				mpbd_pkg::REG_ANIM_COUNT: anim_count_q <= wr_count;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mpbd_pkg::REG_DEBOUNCE:   prdata = mpbd_pkg::PDATA_W'(debounce_q);
			mpbd_pkg::REG_MULTI:      prdata = mpbd_pkg::PDATA_W'(multi_q);
			mpbd_pkg::REG_ANIM_COUNT: prdata = mpbd_pkg::PDATA_W'(anim_count_q);
			default:                  prdata = '0;
		endcase
	end

	assign eff_count = (anim_count_q == '0) ? mpbd_pkg::COUNT_W'(1) : anim_count_q;

	// recompute (index + 1) mod count whenever the count is written
	mpbd_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_wr && (reg_sel == mpbd_pkg::REG_ANIM_COUNT)),
		.dividend  ({1'b0, index_q} + 1'b1),
		.divisor   ((wr_count == '0) ? mpbd_pkg::COUNT_W'(1) : wr_count),
		.status    (mod_status),
		.remainder (mod_rem)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready) && !mod_status.busy;
	assign in_ready = !mod_status.busy && (!valid_s1 || advance);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			time_s1   <= time_ms;
		end
	end

	always_comb begin
		elapsed       = time_s1 - last_press_q;
		press_ok      = (opcode_s1 == mpbd_pkg::OP_EDGE) &&
			(elapsed >= mpbd_pkg::TIME_W'(debounce_q));
		decode_ok     = (opcode_s1 == mpbd_pkg::OP_POLL) && (pending_q != '0) &&
			(elapsed > mpbd_pkg::TIME_W'(multi_q));
		base_count    = (pending_q == '0) ? mpbd_pkg::COUNT_W'(1) : pending_q;
		pending_nx    = pending_q;
		index_nx      = index_q;
		index_next_nx = index_next_q;
		boot_nx       = boot_q;
		action_nx     = mpbd_pkg::ACT_NONE;
		count_nx      = '0;
		index_inc     = {1'b0, index_next_q} + 1'b1;

		if (press_ok) begin
			if ((elapsed < mpbd_pkg::TIME_W'(multi_q)) && (base_count != mpbd_pkg::COUNT_MAX)) begin
				pending_nx = base_count + 1'b1;
			end else begin
				pending_nx = base_count;
			end
		end else if (decode_ok) begin
			count_nx   = pending_q;
			pending_nx = '0;
			case (pending_q)
				mpbd_pkg::BOOT_PRESSES: begin
					boot_nx   = 1'b1;
					action_nx = mpbd_pkg::ACT_BOOT;
				end
				mpbd_pkg::SLEEP_PRESSES: begin
					action_nx = mpbd_pkg::ACT_SLEEP;
				end
				mpbd_pkg::NEXT_PRESSES: begin
					index_nx      = index_next_q;
					index_next_nx = (index_inc == {1'b0, eff_count}) ? '0 :
						index_inc[mpbd_pkg::COUNT_W-1:0];
					boot_nx       = 1'b0;
					action_nx     = mpbd_pkg::ACT_NEXT;
				end
				default: begin
					action_nx = mpbd_pkg::ACT_PRESS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_press_q <= '0;
			pending_q    <= '0;
			index_q      <= '0;
			index_next_q <= IDX_NEXT_RESET;
			boot_q       <= 1'b0;
		end else if (mod_status.done) begin
			index_next_q <= mod_rem;
		end else if (advance) begin
			if (press_ok) begin
				last_press_q <= time_s1;
			end
			pending_q    <= pending_nx;
			index_q      <= index_nx;
			index_next_q <= index_next_nx;
			boot_q       <= boot_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q    <= action_nx;
			count_q     <= count_nx;
			index_out_q <= index_nx;
			boot_out_q  <= boot_nx;
		end
	end

	assign out_valid         = out_valid_q;
	assign action            = action_q;
	assign press_count       = count_q;
	assign animation_index   = index_out_q;
	assign bootloader_active = boot_out_q;

	`MPBD_ASSERT_IMPL(a_busy_blocks_input, mod_status.busy, !in_ready && !advance)
	`MPBD_ASSERT_IMPL(a_next_index_in_range, !mod_status.busy, index_next_q < eff_count)
	`MPBD_ASSERT_NEXT(a_press_leaves_count, advance && press_ok, pending_q != '0)
	`MPBD_ASSERT_NEXT(a_next_takes_precomputed,
		advance && (action_nx == mpbd_pkg::ACT_NEXT), index_q == $past(index_next_q))
	`MPBD_ASSERT_NEXT(a_decode_clears_count, advance && decode_ok, pending_q == '0)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 120;

	typedef struct {
		logic        op;
		logic [31:0] t;
	} event_t;

	typedef struct {
		mpbd_pkg::action_t act;
		logic [7:0]  cnt;
		logic [7:0]  idx;
		logic        boot;
	} decode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = mpbd_pkg::OP_POLL;
	logic [31:0] time_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] action;
	logic [7:0] press_count;
	logic [7:0] animation_index;
	logic bootloader_active;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mpbd_pkg::PADDR_W-1:0] paddr = '0;
	logic [mpbd_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mpbd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	multi_press_button_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.press_count(press_count),
		.animation_index(animation_index),
		.bootloader_active(bootloader_active),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// register copies
	logic [15:0] cfg_deb = mpbd_pkg::DEBOUNCE_RESET;
	logic [15:0] cfg_mpm = mpbd_pkg::MULTI_RESET;
	logic [7:0] cfg_anim = mpbd_pkg::ANIM_COUNT_RESET;

	// press state copies
	logic [31:0] last_t = '0;
	logic [7:0] pend = '0;
	logic [7:0] idx = '0;
	logic boot = 1'b0;

	event_t pending_events[$];
	decode_t decodes_due[$];
	event_t ev;
	decode_t due;

	int unsigned snd_idle = 0;
	int unsigned rcv_idle = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned n_accepted = 0;
	int unsigned n_writes = 0;
	int unsigned n_pushed = 0;
	int unsigned n_act[5] = '{0, 0, 0, 0, 0};
	int unsigned n_saturated = 0;
	logic [31:0] gen_t = '0;

	always #2 clk = ~clk;

	function automatic decode_t decode_event(logic op, logic [31:0] now);
		decode_t r;
		logic [31:0] el;
		logic [8:0] n;
		logic [8:0] nxt;
		el = now - last_t;
		r.act = mpbd_pkg::ACT_NONE;
		r.cnt = '0;
		if (op == mpbd_pkg::OP_EDGE) begin
			if (el >= {16'd0, cfg_deb}) begin
				last_t = now;
				if (pend == 8'd0)
					pend = 8'd1;
				if (el < {16'd0, cfg_mpm} && pend != mpbd_pkg::COUNT_MAX)
					pend = pend + 8'd1;
			end
		end else if (pend != 8'd0 && el > {16'd0, cfg_mpm}) begin
			n = (cfg_anim == 8'd0) ? 9'd1 : {1'b0, cfg_anim};
			r.cnt = pend;
			if (pend == mpbd_pkg::BOOT_PRESSES) begin
				boot = 1'b1;
				r.act = mpbd_pkg::ACT_BOOT;
			end else if (pend == mpbd_pkg::SLEEP_PRESSES) begin
				r.act = mpbd_pkg::ACT_SLEEP;
			end else if (pend == mpbd_pkg::NEXT_PRESSES) begin
				nxt = ({1'b0, idx} + 9'd1) % n;
				idx = nxt[7:0];
				boot = 1'b0;
				r.act = mpbd_pkg::ACT_NEXT;
			end else begin
				r.act = mpbd_pkg::ACT_PRESS;
			end
			pend = 8'd0;
		end
		r.idx = idx;
		r.boot = boot;
		return r;
	endfunction

	task automatic report(string what, int unsigned want, int unsigned got);
		errors++;
		if (errors <= 60)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic push_event(logic op, logic [31:0] t);
		event_t e;
		e.op = op;
		e.t = t;
		pending_events.push_back(e);
		n_pushed++;
	endtask

	// presses with gaps around the debounce and multi-press thresholds, some bounces and early polls, then a decoding poll
	task automatic make_burst(int unsigned n);
		int unsigned d;
		int unsigned m;
		int unsigned g;
		logic [31:0] t;
		d = 32'(cfg_deb);
		m = 32'(cfg_mpm);
		t = gen_t + d + m + 1 + $urandom_range(50);
		push_event(mpbd_pkg::OP_EDGE, t);
		for (int unsigned i = 1; i < n; i++) begin
			if (d < m) begin
				case ($urandom_range(9))
					0: g = d;
					1: g = m - 1;
					default: g = $urandom_range(m - 1, d);
				endcase
			end else begin
				g = d + $urandom_range(20);
			end
			if (d > 0 && $urandom_range(4) == 0)
				push_event(mpbd_pkg::OP_EDGE, t + $urandom_range(d - 1));
			if ($urandom_range(9) == 0)
				push_event(mpbd_pkg::OP_POLL, t + $urandom_range(g));
			t = t + g;
			push_event(mpbd_pkg::OP_EDGE, t);
		end
		if ($urandom_range(3) == 0)
			push_event(mpbd_pkg::OP_POLL, t + m);
		t = t + m + 1 + $urandom_range(30);
		push_event(mpbd_pkg::OP_POLL, t);
		gen_t = t;
	endtask

	task automatic apb_write(mpbd_pkg::reg_index_t r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			mpbd_pkg::REG_DEBOUNCE: cfg_deb = v[15:0];
			mpbd_pkg::REG_MULTI: cfg_mpm = v[15:0];
			mpbd_pkg::REG_ANIM_COUNT: cfg_anim = v[7:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || decodes_due.size() != 0);
	endtask

	function automatic int unsigned pick_presses();
		case ($urandom_range(9))
			0, 1, 7: return 3;
			2, 9: return 4;
			3, 8: return 5;
			4: return 1;
			5: return 2;
			default: return $urandom_range(12, 6);
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			decodes_due.push_back(decode_event(opcode, time_ms));
			n_accepted++;
		end
		if (!in_valid || in_ready) begin
			if (pending_events.size() != 0 && $urandom_range(99) >= snd_idle) begin
				ev = pending_events.pop_front();
				in_valid <= 1'b1;
				opcode <= ev.op;
				time_ms <= ev.t;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
		if (out_valid && out_ready) begin
			if (decodes_due.size() == 0) begin
				report("unexpected item, action", 0, action);
			end else begin
				due = decodes_due.pop_front();
				if (action !== due.act)
					report("action", due.act, action);
				if (press_count !== due.cnt)
					report("press_count", due.cnt, press_count);
				if (animation_index !== due.idx)
					report("animation_index", due.idx, animation_index);
				if (bootloader_active !== due.boot)
					report("bootloader_active", due.boot, bootloader_active);
				if (due.act <= mpbd_pkg::ACT_PRESS)
					n_act[due.act]++;
				if (due.cnt == mpbd_pkg::COUNT_MAX)
					n_saturated++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int unsigned deb_tab[9];
		int unsigned mpm_tab[9];
		int unsigned anim_tab[9];
		deb_tab = '{20, 0, 10, 65535, 0, 100, 0, 5, 0};
		mpm_tab = '{300, 65535, 100, 65535, 0, 65535, 0, 40, 0};
		anim_tab = '{255, 255, 2, 1, 0, 7, 0, 3, 0};
		snd_idle = 7;
		rcv_idle = 77;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings
		push_event(mpbd_pkg::OP_POLL, 32'd0);
		push_event(mpbd_pkg::OP_EDGE, 32'd100);
		push_event(mpbd_pkg::OP_EDGE, 32'd120);
		push_event(mpbd_pkg::OP_POLL, 32'd300);
		push_event(mpbd_pkg::OP_EDGE, 32'd400);
		push_event(mpbd_pkg::OP_POLL, 32'd901);
		for (int unsigned i = 0; i < 5; i++)
			push_event(mpbd_pkg::OP_EDGE, 32'd2000 + 100 * i);
		push_event(mpbd_pkg::OP_POLL, 32'd2900);
		push_event(mpbd_pkg::OP_POLL, 32'd2901);
		for (int unsigned i = 0; i < 4; i++)
			push_event(mpbd_pkg::OP_EDGE, 32'd4000 + 100 * i);
		push_event(mpbd_pkg::OP_POLL, 32'd5000);
		for (int unsigned i = 0; i < 3; i++)
			push_event(mpbd_pkg::OP_EDGE, 32'd6000 + 100 * i);
		push_event(mpbd_pkg::OP_POLL, 32'd7000);
		push_event(mpbd_pkg::OP_EDGE, 32'hFFFF_FF00);
		push_event(mpbd_pkg::OP_EDGE, 32'h0000_0010);
		push_event(mpbd_pkg::OP_POLL, 32'hFFFF_FFFF);
		wait_drained();
		repeat (4) @(negedge clk);

		for (int unsigned p = 0; p < 9; p++) begin
			if (p == 6 || p == 8) begin
				deb_tab[p] = $urandom_range(200);
				mpm_tab[p] = $urandom_range(2000, deb_tab[p]);
				anim_tab[p] = $urandom_range(255, 1);
			end
			apb_write(mpbd_pkg::REG_DEBOUNCE, deb_tab[p]);
			apb_write(mpbd_pkg::REG_MULTI, mpm_tab[p]);
			apb_write(mpbd_pkg::REG_ANIM_COUNT, anim_tab[p]);
			@(negedge clk);
			if (p < 3) begin
				snd_idle = 7;
				rcv_idle = 77;
			end else if (p < 6) begin
				snd_idle = 77;
				rcv_idle = 7;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if (p >= 6)
				gen_t = $urandom;
			n_pushed = 0;
			if (p == 1)
				make_burst(300);
			while (n_pushed < ITEMS_PER_PHASE) begin
				if ($urandom_range(9) == 0) begin
					for (int unsigned k = 0; k < 3; k++)
						push_event(1'($urandom_range(1)), $urandom);
				end else begin
					make_burst(pick_presses());
				end
			end
			wait_drained();
			repeat (4) @(negedge clk);
		end

		repeat (10) @(negedge clk);
		while (decodes_due.size() != 0) begin
			due = decodes_due.pop_front();
			report("missing item, action", due.act, 0);
		end
		$display("ran %0d items through %0d register writes, incl. zero and full-scale timings",
			n_accepted, n_writes);
		$display("decodes: boot %0d sleep %0d next %0d forwarded %0d, saturated counts %0d",
			n_act[mpbd_pkg::ACT_BOOT], n_act[mpbd_pkg::ACT_SLEEP], n_act[mpbd_pkg::ACT_NEXT],
			n_act[mpbd_pkg::ACT_PRESS], n_saturated);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
